// ----- rtl/first_substring_match_core_macros.svh -----
// Assertion macros shared by the search core.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef FIRST_SUBSTRING_MATCH_CORE_MACROS_SVH
`define FIRST_SUBSTRING_MATCH_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent
`define FSMATCH_ASSERT_HOLDS(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("first_substring_match_core: check failed");
// Consequent must hold in the cycle after the antecedent
`define FSMATCH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("first_substring_match_core: check failed");
`else
`define FSMATCH_ASSERT_HOLDS(label, clk, rstn, ante, cons)
`define FSMATCH_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/fsmatch_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fsmatch_pkg;

    // Parameter defaults
    localparam int PATTERN_MAX_DEFAULT = 32;
    localparam int TEXT_MAX_DEFAULT    = 65536;

    // Field and register widths
    localparam int BYTE_W            = 8;
    localparam int LEN_W             = 6;
    localparam int MATCH_INDEX_W     = 16;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int PATTERN_REG_COUNT = 4;
    localparam int PATTERN_BYTES     = PATTERN_REG_COUNT * CFG_DATA_W / BYTE_W;
    localparam int PAT_IDX_W         = $clog2(PATTERN_BYTES);
    localparam int S_TDATA_W         = 8;
    localparam int M_TDATA_W         = 24;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_0      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_1      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_2      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_3      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 3'd4;

    typedef logic [PATTERN_BYTES-1:0][BYTE_W-1:0] pattern_bytes_t;

endpackage

`default_nettype wire

// ----- rtl/fsmatch_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fsmatch_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                                aclk,
    input  logic                                shift_en,
    input  logic [fsmatch_pkg::BYTE_W-1:0]      byte_in,
    output logic [fsmatch_pkg::BYTE_W-1:0]      byte_out,
    input  fsmatch_pkg::pattern_bytes_t         pattern_bytes,
    input  logic [fsmatch_pkg::LEN_W-1:0]       eff_len,
    input  logic                                match_in,
    output logic                                match_out
);
    import fsmatch_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic [LEN_W-1:0]  pat_sel;
    logic              active;
    logic              byte_eq;

    // This cell sees window slot CELL_INDEX, which lines up with the pattern
    // byte counted back from the end of the pattern
    assign active  = eff_len > LEN_W'(CELL_INDEX);
    assign pat_sel = eff_len - LEN_W'(1) - LEN_W'(CELL_INDEX);
    assign byte_eq = (byte_in == pattern_bytes[pat_sel[PAT_IDX_W-1:0]]);

    // Extend the running match along the row; unused cells pass it on
    assign match_out = match_in & (~active | byte_eq);

    // Hold the window byte and hand it to the next cell on a shift
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

endmodule

`default_nettype wire

// ----- rtl/first_substring_match_core.sv -----
// Leftmost exact substring search over a byte stream.
// Load the pattern through the cfg channel: indexes 0..3 carry pattern bytes
// 0..31 (byte k at bits 8k+7:8k, word 0 lowest), index 4 the pattern length
// (0 acts as 1, values above the cell count are clamped). Writes are taken
// in every cycle. Text bytes enter on the s_ channel, one per transfer, and
// the transfer with s_tlast high ends the text. One result transfer per text
// leaves on the m_ channel: found, the start index of the first match
// (0 when not found) and too_long when the text ran past TEXT_MAX bytes.
// Throughput is one text byte per cycle while s_tready is high: each byte
// shifts through a row of compare cells that checks the newest alignment in
// the cycle it arrives. The result is registered and shows on m_tvalid in the
// cycle after the last byte is taken. The single output register holds the
// result while the receiver stalls; s_tready stays low only while that
// register is full and not being drained. Reset is synchronous; it clears the
// search state and loads the reset pattern (all zeros, length 1). No clearing
// pass is needed, and the search state clears itself after each result.
`timescale 1ns / 1ps
`default_nettype none

`include "first_substring_match_core_macros.svh"

module first_substring_match_core #(
    parameter int PATTERN_MAX = fsmatch_pkg::PATTERN_MAX_DEFAULT,
    parameter int TEXT_MAX    = fsmatch_pkg::TEXT_MAX_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // text input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [fsmatch_pkg::S_TDATA_W-1:0]    s_tdata,   // [7:0] text_byte
    input  logic                                 s_tlast,   // last_byte
    // result output
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] found, [16:1] match_index, [17] too_long, [23:18] zero
    output logic [fsmatch_pkg::M_TDATA_W-1:0]    m_tdata,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fsmatch_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fsmatch_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import fsmatch_pkg::*;

    localparam int CELL_COUNT = (PATTERN_MAX < PATTERN_BYTES) ? PATTERN_MAX : PATTERN_BYTES;
    localparam int POS_W      = $clog2(TEXT_MAX + 2);
    localparam int CMP_W      = (POS_W > LEN_W) ? POS_W : LEN_W;

    // Configuration registers
    logic [PATTERN_REG_COUNT-1:0][CFG_DATA_W-1:0] pattern_reg;
    logic [LEN_W-1:0]                             length_reg;
    pattern_bytes_t                               pattern_bytes;
    logic [LEN_W-1:0]                             eff_len;

    // Search state
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic                     match_seen_reg, match_seen_next;
    logic [MATCH_INDEX_W-1:0] first_start_reg, first_start_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]     out_data_reg, out_data_next;

    // Cell row
    logic [CELL_COUNT-1:0][BYTE_W-1:0] window;
    logic [CELL_COUNT:0]               match_chain;

    logic                     s_fire;
    logic                     in_range;
    logic                     shift_en;
    logic                     window_full;
    logic                     hit;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         lenm1_ext;
    logic [CMP_W-1:0]         start_ext;
    logic                     res_found;
    logic [MATCH_INDEX_W-1:0] res_index;

    assign cfg_ready = 1'b1;
    assign s_tready  = ~out_valid_reg | m_tready;
    assign s_fire    = s_tvalid & s_tready;

    // Take configuration writes; indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            length_reg  <= LEN_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_PATTERN_0:      pattern_reg[0] <= cfg_data;
                CFG_PATTERN_1:      pattern_reg[1] <= cfg_data;
                CFG_PATTERN_2:      pattern_reg[2] <= cfg_data;
                CFG_PATTERN_3:      pattern_reg[3] <= cfg_data;
                CFG_PATTERN_LENGTH: length_reg     <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign pattern_bytes = pattern_reg;

    // Clamp the length to the cells present, zero acts as one
    always_comb begin
        priority if (length_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (length_reg > LEN_W'(CELL_COUNT)) begin
            eff_len = LEN_W'(CELL_COUNT);
        end else begin
            eff_len = length_reg;
        end
    end

    // Bytes past the text limit are not searched; the position stops at TEXT_MAX + 1
    assign in_range = pos_reg < POS_W'(TEXT_MAX);
    assign shift_en = s_fire & in_range;

    // Row of compare cells, newest byte enters cell 0
    assign match_chain[0] = 1'b1;

    for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
        logic [BYTE_W-1:0] cell_in;
        if (k == 0) begin : g_head
            assign cell_in = s_tdata[BYTE_W-1:0];
        end else begin : g_body
            assign cell_in = window[k-1];
        end
        fsmatch_cell #(
            .CELL_INDEX (k)
        ) u_cell (
            .aclk          (aclk),
            .shift_en      (shift_en),
            .byte_in       (cell_in),
            .byte_out      (window[k]),
            .pattern_bytes (pattern_bytes),
            .eff_len       (eff_len),
            .match_in      (match_chain[k]),
            .match_out     (match_chain[k+1])
        );
    end

    // Check an alignment only once the current text fills it
    assign pos_ext     = CMP_W'(pos_reg);
    assign lenm1_ext   = CMP_W'(eff_len - LEN_W'(1));
    assign window_full = pos_ext >= lenm1_ext;
    assign start_ext   = pos_ext - lenm1_ext;
    assign hit         = shift_en & ~match_seen_reg & window_full & match_chain[CELL_COUNT];

    assign res_found = match_seen_reg | hit;
    assign res_index = match_seen_reg ? first_start_reg
                     : (hit ? MATCH_INDEX_W'(start_ext) : '0);

    // Advance the search state; clear it when the last byte is taken
    always_comb begin
        pos_next         = pos_reg;
        match_seen_next  = match_seen_reg;
        first_start_next = first_start_reg;
        if (s_fire) begin
            if (s_tlast) begin
                pos_next         = '0;
                match_seen_next  = 1'b0;
                first_start_next = '0;
            end else begin
                pos_next         = in_range ? (pos_reg + POS_W'(1)) : POS_W'(TEXT_MAX + 1);
                match_seen_next  = res_found;
                first_start_next = res_index;
            end
        end
    end

    // Load the result on the last byte, drop it once transferred
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (s_fire && s_tlast) begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            out_data_next[0]                 = res_found;
            out_data_next[MATCH_INDEX_W:1]   = res_index;
            out_data_next[MATCH_INDEX_W+1]   = ~in_range;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            match_seen_reg  <= 1'b0;
            first_start_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            pos_reg         <= pos_next;
            match_seen_reg  <= match_seen_next;
            first_start_reg <= first_start_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Checks
    `FSMATCH_ASSERT_NEXT(a_last_loads_result, aclk, aresetn, s_fire && s_tlast, m_tvalid)
    `FSMATCH_ASSERT_NEXT(a_last_clears_state, aclk, aresetn, s_fire && s_tlast,
        (pos_reg == '0) && !match_seen_reg && (first_start_reg == '0))
    `FSMATCH_ASSERT_HOLDS(a_not_found_index_zero, aclk, aresetn, m_tvalid && !m_tdata[0],
        m_tdata[MATCH_INDEX_W:1] == '0)
    `FSMATCH_ASSERT_HOLDS(a_unseen_start_zero, aclk, aresetn, !match_seen_reg,
        first_start_reg == '0)
    `FSMATCH_ASSERT_HOLDS(a_ready_when_empty, aclk, aresetn, !out_valid_reg, s_tready)

endmodule

`default_nettype wire
